### design/sparse_peak_detect_top_n_defines.svh
// Assertion macros for the sparse peak detector checker.
// No dependencies; included by the checker file only.
`ifndef SPARSE_PEAK_DETECT_TOP_N_DEFINES_SVH
`define SPARSE_PEAK_DETECT_TOP_N_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("spd checker: property failed");

// next-cycle implication, disabled during reset
`define SPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("spd checker: property failed");

// behavior in the cycle after reset is applied
`define SPD_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error("spd checker: reset property failed");

`endif

### design/spd_pkg.sv
// Shared constants, opcodes and controller/datapath interface structs
// for the sparse peak detector. No dependencies.
package spd_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_STARS  = 160;

    localparam int PIX_W = 16;
    localparam int CFG_W = 16;

    // opcodes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
    localparam logic [1:0] REG_LIMIT  = 2'd3;

    typedef struct packed {
        logic latch;      // take input word
        logic pos_adj;    // wrap raster position, latch pixel coords
        logic line_rd;    // read line buffer column
        logic win_upd;    // shift window, write line buffer, advance raster
        logic ins_start;  // start list insertion
        logic step_rd;    // read entry above pos, or place at top
        logic step_cmp;   // shift entry down or place new entry
        logic clear;      // clear list and raster position
        logic ent_rd;     // read entry for opcode read
        logic ent_cap;    // capture read entry
        logic out_load;   // load result register
    } spd_cmd_t;

    typedef struct packed {
        logic off_frame;
        logic peak;
        logic has_room;
        logic reject;
        logic pos_zero;
        logic greater;
        logic out_free;
    } spd_stat_t;

endpackage

### design/spd_ctrl.sv
// Controller state machine of the sparse peak detector.
// Depends on spd_pkg for opcodes and the command/status structs.
module spd_ctrl
    import spd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_opcode,
    output logic       s_ready,
    input  spd_stat_t  stat,
    output spd_cmd_t   cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_POS  = 4'd1;
    localparam logic [3:0] ST_LRD  = 4'd2;
    localparam logic [3:0] ST_WIN  = 4'd3;
    localparam logic [3:0] ST_PEAK = 4'd4;
    localparam logic [3:0] ST_ICHK = 4'd5;
    localparam logic [3:0] ST_SRD  = 4'd6;
    localparam logic [3:0] ST_SCMP = 4'd7;
    localparam logic [3:0] ST_CLR  = 4'd8;
    localparam logic [3:0] ST_RDI  = 4'd9;
    localparam logic [3:0] ST_RDD  = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch = 1'b1;
                    unique case (s_opcode)
                        OP_PUSH:  state_next = ST_POS;
                        OP_CLEAR: state_next = ST_CLR;
                        OP_READ:  state_next = ST_RDI;
                        OP_NOP:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_POS: begin
                cmd.pos_adj = 1'b1;
                state_next  = stat.off_frame ? ST_DONE : ST_LRD;
            end
            ST_LRD: begin
                cmd.line_rd = 1'b1;
                state_next  = ST_WIN;
            end
            ST_WIN: begin
                cmd.win_upd = 1'b1;
                state_next  = ST_PEAK;
            end
            ST_PEAK: begin
                if (stat.peak) begin
                    cmd.ins_start = 1'b1;
                    state_next    = stat.has_room ? ST_SRD : ST_ICHK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_ICHK: begin
                state_next = stat.reject ? ST_DONE : ST_SRD;
            end
            ST_SRD: begin
                cmd.step_rd = 1'b1;
                state_next  = stat.pos_zero ? ST_DONE : ST_SCMP;
            end
            ST_SCMP: begin
                cmd.step_cmp = 1'b1;
                state_next   = stat.greater ? ST_SRD : ST_DONE;
            end
            ST_CLR: begin
                cmd.clear  = 1'b1;
                state_next = ST_DONE;
            end
            ST_RDI: begin
                cmd.ent_rd = 1'b1;
                state_next = ST_RDD;
            end
            ST_RDD: begin
                cmd.ent_cap = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### design/spd_dp.sv
// Datapath of the sparse peak detector: config registers, raster position,
// line buffer memory, 5x5 window, sorted star list memory and result register.
// Depends on spd_pkg.
module spd_dp
    import spd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_STARS  = DEF_MAX_STARS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic [1:0]       s_opcode,
    input  logic [15:0]      s_pixel_value,
    input  logic [7:0]       s_entry_index,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_star_count,
    output logic [9:0]       m_entry_row,
    output logic [9:0]       m_entry_col,
    output logic [15:0]      m_entry_value,
    output logic             m_entry_valid,
    input  spd_cmd_t         cmd,
    output spd_stat_t        stat
);

    localparam int CAW = $clog2(MAX_WIDTH + 1);   // column incl. width itself
    localparam int RAW = $clog2(MAX_HEIGHT + 2);  // row may pass height by one
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int NW  = $clog2(MAX_STARS + 1);
    localparam int SW  = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
    localparam int EW  = RW + CW + PIX_W;
    localparam int LW  = 4 * PIX_W;

    // configuration
    logic [10:0]      width_reg, height_reg;
    logic [15:0]      thresh_reg;
    logic [7:0]       limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
            thresh_reg <= '0;
            limit_reg  <= 8'd160;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data[10:0];
                REG_THRESH: thresh_reg <= cfg_data[15:0];
                REG_LIMIT:  limit_reg  <= cfg_data[7:0];
            endcase
        end
    end

    // saturated geometry and list limit
    logic [13:0]    w_ext, h_ext;
    logic [CAW-1:0] w_sat;
    logic [RAW-1:0] h_sat;
    logic [8:0]     l_ext;
    logic [NW-1:0]  lim;

    always_comb begin
        w_ext = {3'd0, width_reg};
        h_ext = {3'd0, height_reg};
        l_ext = {1'b0, limit_reg};
        if (w_ext < 14'd5)                 w_sat = CAW'(5);
        else if (w_ext > 14'(MAX_WIDTH))   w_sat = CAW'(MAX_WIDTH);
        else                               w_sat = CAW'(w_ext);
        if (h_ext < 14'd5)                 h_sat = RAW'(5);
        else if (h_ext > 14'(MAX_HEIGHT))  h_sat = RAW'(MAX_HEIGHT);
        else                               h_sat = RAW'(h_ext);
        if (l_ext == 9'd0)                 lim = NW'(1);
        else if (l_ext > 9'(MAX_STARS))    lim = NW'(MAX_STARS);
        else                               lim = NW'(l_ext);
    end

    // latched input word
    logic [1:0]  op_reg;
    logic [15:0] px_reg;
    logic [7:0]  idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg  <= s_opcode;
            px_reg  <= s_pixel_value;
            idx_reg <= s_entry_index;
        end
    end

    // raster position
    logic [RAW-1:0] row_reg, pr_reg, row_adj;
    logic [CAW-1:0] col_reg, pc_reg, col_adj, col_inc;

    always_comb begin
        if (col_reg >= w_sat) begin
            col_adj = '0;
            row_adj = row_reg + RAW'(1);
        end else begin
            col_adj = col_reg;
            row_adj = row_reg;
        end
        col_inc = pc_reg + CAW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (cmd.pos_adj) begin
            row_reg <= row_adj;
            col_reg <= col_adj;
        end else if (cmd.win_upd) begin
            if (col_inc >= w_sat) begin
                col_reg <= '0;
                row_reg <= pr_reg + RAW'(1);
            end else begin
                col_reg <= col_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pos_adj) begin
            pr_reg <= row_adj;
            pc_reg <= col_adj;
        end
    end

    // line buffer: one word per column, four row lanes
    logic [LW-1:0] line_mem [MAX_WIDTH];
    logic [LW-1:0] line_rdata, line_wdata;

    always_ff @(posedge aclk) begin
        if (cmd.line_rd) begin
            line_rdata <= line_mem[pc_reg[CW-1:0]];
        end
    end

    always_comb begin
        line_wdata = line_rdata;
        line_wdata[pr_reg[1:0]*PIX_W +: PIX_W] = px_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.win_upd) begin
            line_mem[pc_reg[CW-1:0]] <= line_wdata;
        end
    end

    // 5x5 window
    logic [15:0] win_reg [5][5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 5; r++) begin
                for (int c = 0; c < 5; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (cmd.win_upd) begin
            for (int r = 0; r < 5; r++) begin
                for (int c = 0; c < 4; c++) begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
            end
            for (int k = 0; k < 4; k++) begin
                win_reg[k][4] <= line_rdata[(2'(pr_reg[1:0] + 2'(k)))*PIX_W +: PIX_W];
            end
            win_reg[4][4] <= px_reg;
        end
    end

    logic [15:0] ctr;
    logic        pk;

    always_comb begin
        ctr = win_reg[2][2];
        pk  = (ctr > thresh_reg) && (pr_reg >= RAW'(4)) && (pc_reg >= CAW'(4));
        for (int r = 1; r <= 3; r++) begin
            for (int c = 1; c <= 3; c++) begin
                if (!(r == 2 && c == 2) && ctr <= win_reg[r][c]) pk = 1'b0;
            end
        end
        for (int r = 0; r <= 4; r += 2) begin
            for (int c = 0; c <= 4; c += 2) begin
                if (!(r == 2 && c == 2) && ctr <= win_reg[r][c]) pk = 1'b0;
            end
        end
    end

    // sorted star list: {row, col, value}
    logic [EW-1:0]  star_mem [MAX_STARS];
    logic [EW-1:0]  star_rdata, new_entry, star_wdata;
    logic [SW-1:0]  star_raddr, star_waddr, pos_reg;
    logic           star_re, star_we;
    logic [NW-1:0]  count_reg;
    logic           hit;
    logic [15:0]    rd_val;

    assign new_entry = {RW'(pr_reg - RAW'(2)), CW'(pc_reg - CAW'(2)), ctr};
    assign rd_val    = star_rdata[PIX_W-1:0];
    assign hit       = ({1'b0, idx_reg} < 9'(count_reg)) && ({1'b0, idx_reg} < 9'(MAX_STARS));

    always_comb begin
        star_re    = 1'b0;
        star_raddr = pos_reg - SW'(1);
        star_we    = 1'b0;
        star_waddr = pos_reg;
        star_wdata = new_entry;
        if (cmd.ins_start && !(count_reg < lim)) begin
            star_re    = 1'b1;
            star_raddr = SW'(count_reg - NW'(1));
        end
        if (cmd.ent_rd && hit) begin
            star_re    = 1'b1;
            star_raddr = idx_reg[SW-1:0];
        end
        if (cmd.step_rd) begin
            if (pos_reg == '0) star_we = 1'b1;
            else               star_re = 1'b1;
        end
        if (cmd.step_cmp) begin
            star_we = 1'b1;
            if (ctr > rd_val) star_wdata = star_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (star_re) star_rdata <= star_mem[star_raddr];
        if (star_we) star_mem[star_waddr] <= star_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.ins_start && count_reg < lim) begin
            count_reg <= count_reg + NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins_start) begin
            pos_reg <= (count_reg < lim) ? SW'(count_reg) : SW'(count_reg - NW'(1));
        end else if (cmd.step_cmp && ctr > rd_val) begin
            pos_reg <= pos_reg - SW'(1);
        end
    end

    // read result
    logic        hit_reg;
    logic [9:0]  er_reg, ec_reg;
    logic [15:0] ev_reg;

    always_ff @(posedge aclk) begin
        if (cmd.ent_rd) hit_reg <= hit;
        if (cmd.latch) begin
            er_reg <= '0;
            ec_reg <= '0;
            ev_reg <= '0;
        end else if (cmd.ent_cap && hit_reg) begin
            er_reg <= 10'(star_rdata[EW-1 -: RW]);
            ec_reg <= 10'(star_rdata[PIX_W +: CW]);
            ev_reg <= rd_val;
        end
    end

    // result register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_star_count  <= 8'(count_reg);
            m_entry_row   <= er_reg;
            m_entry_col   <= ec_reg;
            m_entry_value <= ev_reg;
            m_entry_valid <= (op_reg == OP_READ) && hit_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        stat           = '0;
        stat.off_frame = (row_adj >= h_sat);
        stat.peak      = pk;
        stat.has_room  = (count_reg < lim);
        stat.reject    = (ctr <= rd_val);
        stat.pos_zero  = (pos_reg == '0);
        stat.greater   = (ctr > rd_val);
        stat.out_free  = !m_valid_reg || m_ready;
    end

endmodule

### design/sparse_peak_detect_top_n.sv
// A push wraps the raster position and, on frame, reads the line buffer, shifts the
// window and tests for a peak; a peak may be placed in the sorted list, shifting lower
// entries down. One word at a time: the next is accepted in the cycle after its result
// is loaded, even while that result still waits. Reset (aresetn low, synchronous)
// clears control, list count and raster position and sets config to its defaults;
// line buffer and list memories are not cleared and need no clearing pass.
module sparse_peak_detect_top_n
    import spd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_STARS  = DEF_MAX_STARS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_opcode,
    input  logic [15:0]      s_pixel_value,
    input  logic [7:0]       s_entry_index,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_star_count,
    output logic [9:0]       m_entry_row,
    output logic [9:0]       m_entry_col,
    output logic [15:0]      m_entry_value,
    output logic             m_entry_valid
);

    spd_cmd_t  cmd;
    spd_stat_t stat;

    spd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spd_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_STARS  (MAX_STARS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_opcode      (s_opcode),
        .s_pixel_value (s_pixel_value),
        .s_entry_index (s_entry_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_star_count  (m_star_count),
        .m_entry_row   (m_entry_row),
        .m_entry_col   (m_entry_col),
        .m_entry_value (m_entry_value),
        .m_entry_valid (m_entry_valid),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

### design/spd_checker.sv
// Port-level checker for the sparse peak detector, bound to the top level.
// Depends on spd_pkg and sparse_peak_detect_top_n_defines.svh.
`include "sparse_peak_detect_top_n_defines.svh"

module spd_checker
    import spd_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             cfg_we,
    input logic [1:0]       cfg_index,
    input logic [CFG_W-1:0] cfg_data,
    input logic             s_valid,
    input logic             s_ready,
    input logic [1:0]       s_opcode,
    input logic [15:0]      s_pixel_value,
    input logic [7:0]       s_entry_index,
    input logic             m_valid,
    input logic             m_ready,
    input logic [7:0]       m_star_count,
    input logic [9:0]       m_entry_row,
    input logic [9:0]       m_entry_col,
    input logic [15:0]      m_entry_value,
    input logic             m_entry_valid
);

    // no result straight out of reset
    `SPD_ASSERT_RST(a_rst_no_result, !m_valid)
    // a miss or a non-read word carries zero entry fields
    `SPD_ASSERT_IMPL(a_miss_zero, m_valid && !m_entry_valid, m_entry_row == 10'd0 && m_entry_col == 10'd0 && m_entry_value == 16'd0)
    // one word at a time: ready drops after an accept
    `SPD_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)
    // stalled result holds
    `SPD_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_star_count) && $stable(m_entry_valid))

endmodule

bind sparse_peak_detect_top_n spd_checker u_spd_checker (.*);
